@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros shared by the gate datapath modules
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge of clk, off while rst_n is low
`define NGH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// condition that must never be seen on a rising edge of clk out of reset
`define NGH_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

@@ hdl/ngh_pkg.sv @@
// ---------------------------------------------------------------------------
// ngh_pkg
// types, constants and helpers of the noise gate with hold and envelope
// ---------------------------------------------------------------------------
`default_nettype none

package ngh_pkg;

  // sample and coefficient formats
  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_FRAC_BITS = 16;
  localparam int GAIN_BITS      = COEF_FRAC_BITS + 1;
  localparam int COEF_BITS      = COEF_FRAC_BITS;
  localparam int THR_BITS       = SAMPLE_BITS - 1;
  localparam int HOLD_BITS      = 20;

  localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(1) << COEF_FRAC_BITS;

  // shared multiplier operand widths
  localparam int MUL_A_BITS = (SAMPLE_BITS > GAIN_BITS) ? SAMPLE_BITS : GAIN_BITS;
  localparam int MUL_BITS   = MUL_A_BITS + GAIN_BITS;

  // frame queue between front and back (depth is a power of two)
  localparam int QDEPTH    = 2;
  localparam int QPTR_BITS = $clog2(QDEPTH);
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);

  // configuration port
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [CFG_IDX_BITS-1:0] CFG_GATE_ENABLE    = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_OPEN_THRESHOLD = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] CFG_RISE_COEF      = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] CFG_FALL_COEF      = CFG_IDX_BITS'(3);
  localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD_LENGTH    = CFG_IDX_BITS'(4);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_left;
    logic signed [SAMPLE_BITS-1:0] sample_right;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] gated_left;
    logic signed [SAMPLE_BITS-1:0] gated_right;
    logic [GAIN_BITS-1:0]          gain_now;
  } out_item_t;

  // register file contents seen by front and back
  typedef struct packed {
    logic                 gate_enable;
    logic [THR_BITS-1:0]  open_threshold;
    logic [COEF_BITS-1:0] rise_coef;
    logic [COEF_BITS-1:0] fall_coef;
    logic [HOLD_BITS-1:0] hold_length;
  } cfg_t;

  // classified frame handed from front to back
  typedef struct packed {
    logic     bypass;
    logic     gate_open;
    in_item_t smp;
  } q_entry_t;

  // magnitude of a two's complement sample, most negative maps to 2^(n-1)
  function automatic logic [SAMPLE_BITS-1:0] mag_of(input logic [SAMPLE_BITS-1:0] s);
    logic [SAMPLE_BITS-1:0] neg;
    neg = ~s + 1'b1;
    return s[SAMPLE_BITS-1] ? neg : s;
  endfunction

endpackage

`default_nettype wire

@@ hdl/noise_gate_hold_envelope_unit.sv @@
// ---------------------------------------------------------------------------
// noise_gate_hold_envelope_unit
// stereo noise gate with hold, attack and release envelope
// ---------------------------------------------------------------------------
// Frames enter on in_valid / in_stall as one in_item_t; a transfer happens
// on a rising edge with in_valid high and in_stall low. Results leave on
// out_valid / out_stall as one out_item_t, one result per frame, in order.
// Registers are written through cfg_valid / cfg_ready (always ready) with
// cfg_index selecting enable, threshold, attack, release and hold length.
// A front stage classifies each frame (peak, threshold, hold count) and
// pushes it into a two-entry queue; a back sequencer runs the envelope step
// and both sample scalings through one 24x17 multiplier.
// Gated frame: the back sequencer steps through S_IDLE, S_UPD, S_LEFT,
// S_RIGHT and S_FIN, and takes no new frame until that one is through.
// Bypassed frame (gate disabled): handled in S_IDLE alone, one frame per
// cycle while out_stall does not hold a result.
// Reset (rst_n low, synchronous) clears registers, envelope, hold count
// and the queue. When out_stall holds a result, the back waits, the queue
// fills and then in_stall rises.
// ---------------------------------------------------------------------------
`default_nettype none

module noise_gate_hold_envelope_unit
  import ngh_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  in_item_t                 in_data,
  output logic                     in_stall,
  output logic                     out_valid,
  output out_item_t                out_data,
  input  logic                     out_stall,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  cfg_t     cfg_r;
  logic     q_wr_en;
  q_entry_t q_wr_data;
  logic     q_full;
  logic     q_rd_en;
  q_entry_t q_rd_data;
  logic     q_empty;

  assign cfg_ready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GATE_ENABLE:    cfg_r.gate_enable    <= cfg_data[0];
        CFG_OPEN_THRESHOLD: cfg_r.open_threshold <= cfg_data[THR_BITS-1:0];
        CFG_RISE_COEF:      cfg_r.rise_coef      <= cfg_data[COEF_BITS-1:0];
        CFG_FALL_COEF:      cfg_r.fall_coef      <= cfg_data[COEF_BITS-1:0];
        CFG_HOLD_LENGTH:    cfg_r.hold_length    <= cfg_data[HOLD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // classify incoming frames
  ngh_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .q_wr_en   (q_wr_en),
    .q_wr_data (q_wr_data),
    .q_full    (q_full)
  );

  // frame queue
  ngh_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr_en),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd_en   (q_rd_en),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  // envelope and scaling
  ngh_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_rd_data (q_rd_data),
    .q_empty   (q_empty),
    .q_rd_en   (q_rd_en),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule

`default_nettype wire

@@ hdl/ngh_fifo.sv @@
// ---------------------------------------------------------------------------
// ngh_fifo
// short register queue of classified frames between front and back
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ngh_fifo
  import ngh_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_en,
  input  q_entry_t wr_data,
  output logic     full,
  input  logic     rd_en,
  output q_entry_t rd_data,
  output logic     empty
);

  q_entry_t               store_r [QDEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr_r;
  logic [QPTR_BITS-1:0]   rd_ptr_r;
  logic [QCNT_BITS-1:0]   count_r;

  assign full    = (count_r == QCNT_BITS'(QDEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = store_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_ptr_r] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count_r <= count_r + 1'b1;
      end else if (!wr_en && rd_en) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `NGH_NEVER(a_no_overflow, wr_en && full, "ngh_fifo: push into full queue")
  `NGH_NEVER(a_no_underflow, rd_en && empty, "ngh_fifo: pop from empty queue")

endmodule

`default_nettype wire

@@ hdl/ngh_front.sv @@
// ---------------------------------------------------------------------------
// ngh_front
// accepts frames, finds the peak and decides the gate target and hold
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ngh_front
  import ngh_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     in_valid,
  input  in_item_t in_data,
  output logic     in_stall,
  output logic     q_wr_en,
  output q_entry_t q_wr_data,
  input  logic     q_full
);

  logic [HOLD_BITS-1:0]   hold_r;
  logic [HOLD_BITS-1:0]   hold_nxt;
  logic [SAMPLE_BITS-1:0] mag_left;
  logic [SAMPLE_BITS-1:0] mag_right;
  logic [SAMPLE_BITS-1:0] peak;
  logic                   above;
  logic                   gate_open;

  // a frame transfer needs room in the queue
  assign in_stall = q_full;
  assign q_wr_en  = in_valid && !q_full;

  // peak magnitude against the threshold
  always_comb begin
    mag_left  = mag_of(in_data.sample_left);
    mag_right = mag_of(in_data.sample_right);
    peak      = (mag_left > mag_right) ? mag_left : mag_right;
    above     = (peak > SAMPLE_BITS'(cfg.open_threshold));
  end

  // gate target and hold countdown
  always_comb begin
    if (above) begin
      gate_open = 1'b1;
      hold_nxt  = cfg.hold_length;
    end else if (hold_r != '0) begin
      gate_open = 1'b1;
      hold_nxt  = hold_r - 1'b1;
    end else begin
      gate_open = 1'b0;
      hold_nxt  = hold_r;
    end
  end

  always_comb begin
    q_wr_data.bypass    = !cfg.gate_enable;
    q_wr_data.gate_open = gate_open;
    q_wr_data.smp       = in_data;
  end

  // hold counter only moves on a gated frame transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= '0;
    end else if (q_wr_en && cfg.gate_enable) begin
      hold_r <= hold_nxt;
    end
  end

  `NGH_ASSERT(a_hold_moves_on_transfer,
    $past(rst_n) && (hold_r != $past(hold_r)) |-> $past(q_wr_en && cfg.gate_enable),
    "ngh_front: hold counter changed without a gated transfer")

endmodule

`default_nettype wire

@@ hdl/ngh_back.sv @@
// ---------------------------------------------------------------------------
// ngh_back
// envelope step and sample scaling over one shared multiplier
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ngh_back
  import ngh_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  q_entry_t  q_rd_data,
  input  logic      q_empty,
  output logic      q_rd_en,
  output logic      out_valid,
  output out_item_t out_data,
  input  logic      out_stall
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_LEFT,
    S_RIGHT,
    S_FIN
  } state_t;

  state_t                 state_r;
  q_entry_t               cur_r;
  logic [GAIN_BITS-1:0]   gain_r;
  logic [MUL_BITS-1:0]    mul_p_r;
  logic signed [SAMPLE_BITS-1:0] left_r;
  out_item_t              out_r;
  logic                   out_valid_r;

  logic                   out_free;
  logic                   out_load;
  logic [GAIN_BITS-1:0]   env_d;
  logic [COEF_BITS-1:0]   env_coef;
  logic [MUL_A_BITS-1:0]  mul_a;
  logic [GAIN_BITS-1:0]   mul_b;
  logic [GAIN_BITS-1:0]   env_step;
  logic [SAMPLE_BITS-1:0] prod_mag;
  logic [SAMPLE_BITS-1:0] prod_neg;
  logic [SAMPLE_BITS-1:0] scaled_left;
  logic [SAMPLE_BITS-1:0] scaled_right;

  assign out_free  = !out_valid_r || !out_stall;
  assign q_rd_en   = (state_r == S_IDLE) && !q_empty && (!q_rd_data.bypass || out_free);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // a new result enters the output register this cycle
  assign out_load  = ((state_r == S_IDLE) && q_rd_en && q_rd_data.bypass) ||
                     ((state_r == S_FIN) && out_free);

  // envelope distance to the target and the coefficient for this step
  always_comb begin
    if (q_rd_data.gate_open) begin
      env_d    = GAIN_ONE - gain_r;
      env_coef = (gain_r != GAIN_ONE) ? cfg.rise_coef : cfg.fall_coef;
    end else begin
      env_d    = gain_r;
      env_coef = cfg.fall_coef;
    end
  end

  // shared multiplier operand select
  always_comb begin
    case (state_r)
      S_IDLE: begin
        mul_a = MUL_A_BITS'(env_d);
        mul_b = GAIN_BITS'(env_coef);
      end
      S_LEFT: begin
        mul_a = MUL_A_BITS'(mag_of(cur_r.smp.sample_left));
        mul_b = gain_r;
      end
      S_RIGHT: begin
        mul_a = MUL_A_BITS'(mag_of(cur_r.smp.sample_right));
        mul_b = gain_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // truncated product back to a gain or a signed sample
  always_comb begin
    env_step     = mul_p_r[COEF_FRAC_BITS +: GAIN_BITS];
    prod_mag     = mul_p_r[COEF_FRAC_BITS +: SAMPLE_BITS];
    prod_neg     = ~prod_mag + 1'b1;
    scaled_left  = cur_r.smp.sample_left[SAMPLE_BITS-1]  ? prod_neg : prod_mag;
    scaled_right = cur_r.smp.sample_right[SAMPLE_BITS-1] ? prod_neg : prod_mag;
  end

  // product register
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE || state_r == S_LEFT || state_r == S_RIGHT) begin
      mul_p_r <= mul_a * mul_b;
    end
  end

  // sequencer, envelope state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gain_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_rd_en) begin
            cur_r <= q_rd_data;
            if (q_rd_data.bypass) begin
              out_r.gated_left  <= q_rd_data.smp.sample_left;
              out_r.gated_right <= q_rd_data.smp.sample_right;
              out_r.gain_now    <= gain_r;
            end else begin
              state_r <= S_UPD;
            end
          end
        end
        S_UPD: begin
          gain_r  <= cur_r.gate_open ? (GAIN_ONE - env_step) : env_step;
          state_r <= S_LEFT;
        end
        S_LEFT: begin
          state_r <= S_RIGHT;
        end
        S_RIGHT: begin
          left_r  <= scaled_left;
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_r.gated_left  <= left_r;
            out_r.gated_right <= scaled_right;
            out_r.gain_now    <= gain_r;
            state_r           <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  `NGH_ASSERT(a_gain_in_range, gain_r <= GAIN_ONE,
    "ngh_back: envelope above full gain")
  `NGH_ASSERT(a_gain_moves_in_upd,
    $past(rst_n) && (gain_r != $past(gain_r)) |-> $past(state_r == S_UPD),
    "ngh_back: envelope changed outside its update step")
  `NGH_ASSERT(a_no_overwrite,
    out_valid_r && out_stall |=> !$rose(state_r == S_IDLE) || $stable(out_r),
    "ngh_back: stalled result overwritten")

endmodule

`default_nettype wire
